>>> rtl/smci_pkg.sv
// Package with the shared constants and types of the state mask code interning block.
`timescale 1ns / 1ps

package smci_pkg;

    localparam int DEF_ALPHABET_SIZE = 256;
    localparam int DEF_MASK_BITS     = 32;

    localparam int CMD_W    = 2;
    localparam int CHAR_W   = 8;
    localparam int MASK_W   = 32;
    localparam int CODE_W   = 32;
    localparam int MAXST_W  = 33;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_MAP    = 2'd1,
        CMD_XLATE  = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_ILLEGAL = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

endpackage

>>> rtl/smci_if.sv
// Valid/ready interfaces for the command words and the result words.
`timescale 1ns / 1ps

interface smci_in_if;
    logic                          valid;
    logic                          ready;
    logic [smci_pkg::CMD_W-1:0]    command;
    logic [smci_pkg::CHAR_W-1:0]   char_code;
    logic [smci_pkg::MASK_W-1:0]   state_mask;

    modport source (output valid, output command, output char_code, output state_mask,
                    input ready);
    modport sink   (input valid, input command, input char_code, input state_mask,
                    output ready);
endinterface

interface smci_out_if;
    logic                          valid;
    logic                          ready;
    logic [smci_pkg::CODE_W-1:0]   code;
    logic                          is_new;
    logic [smci_pkg::MAXST_W-1:0]  max_states;
    logic [smci_pkg::STATUS_W-1:0] status;

    modport source (output valid, output code, output is_new, output max_states,
                    output status, input ready);
    modport sink   (input valid, input code, input is_new, input max_states,
                    input status, output ready);
endinterface

>>> rtl/smci_value_table.sv
// Value table memory: one write port and one registered read port.
`timescale 1ns / 1ps

module smci_value_table #(
    parameter int DEPTH = smci_pkg::DEF_ALPHABET_SIZE,
    parameter int WIDTH = smci_pkg::DEF_MASK_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/smci_char_store.sv
// Per-character code and mask memory with valid bits; an empty entry reads as unmapped.
`timescale 1ns / 1ps

module smci_char_store #(
    parameter int DEPTH     = smci_pkg::DEF_ALPHABET_SIZE,
    parameter int MASK_BITS = smci_pkg::DEF_MASK_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_clr,
    input  logic                     i_wr_en,
    input  logic                     i_wr_set,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [$clog2(DEPTH)-1:0] i_wr_code,
    input  logic [MASK_BITS-1:0]     i_wr_mask,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic                     o_rd_hit,
    output logic [$clog2(DEPTH)-1:0] o_rd_code,
    output logic [MASK_BITS-1:0]     o_rd_mask
);

    localparam int IDX_W = $clog2(DEPTH);

    logic [IDX_W+MASK_BITS-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]           r_vld;
    logic                       r_rd_hit;
    logic [IDX_W+MASK_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            r_rd_hit <= r_vld[i_rd_addr];
            if (i_clr) begin
                r_vld <= '0;
            end else if (i_wr_en) begin
                r_vld[i_wr_addr] <= i_wr_set;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && i_wr_set) begin
            r_mem[i_wr_addr] <= {i_wr_code, i_wr_mask};
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_hit  = r_rd_hit;
    assign o_rd_code = r_rd_data[IDX_W+MASK_BITS-1:MASK_BITS];
    assign o_rd_mask = r_rd_data[MASK_BITS-1:0];

endmodule

>>> rtl/state_mask_code_interning.sv
// Top level: command sequencer, value search and result register of the mask interning block.
//
//   channel   direction  handshake          payload
//   i_in      sink       valid / ready      command, char_code, state_mask
//   o_out     source     valid / ready      code, is_new, max_states, status
//   cfg       write      i_cfg_wr_en        i_cfg_wr_data (nucleotide mode)
//
// A map word runs a linear search that reads one stored value per cycle from the value
// table; translate reads the character store, and clear and a zero-mask map word need
// no lookup.
// One word is in work at a time; the next is taken once the result is in the output register.
// Reset is synchronous and empties the character store through its valid bits at once.
// A stalled output holds its word while the next command word is already taken.
`timescale 1ns / 1ps

module state_mask_code_interning #(
    parameter int ALPHABET_SIZE = smci_pkg::DEF_ALPHABET_SIZE,
    parameter int MASK_BITS     = smci_pkg::DEF_MASK_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    smci_in_if.sink     i_in,
    smci_out_if.source  o_out
);

    localparam int IDX_W = $clog2(ALPHABET_SIZE);
    localparam int CNT_W = $clog2(ALPHABET_SIZE + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_XLATE  = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    t_state                          r_state, n_state;
    logic                            r_nt, n_nt;
    logic [CNT_W-1:0]                r_count, n_count;
    logic [MASK_BITS-1:0]            r_largest, n_largest;
    logic [CNT_W-1:0]                r_idx, n_idx;
    logic                            r_pend, n_pend;
    logic                            r_out_valid, n_out_valid;

    logic [IDX_W-1:0]                r_ch_idx, n_ch_idx;
    logic [MASK_BITS-1:0]            r_mask, n_mask;
    logic [IDX_W-1:0]                r_pidx, n_pidx;
    logic [smci_pkg::CODE_W-1:0]     r_res_code, n_res_code;
    logic                            r_res_new, n_res_new;
    smci_pkg::t_status               r_res_status, n_res_status;
    logic [smci_pkg::CODE_W-1:0]     r_out_code, n_out_code;
    logic                            r_out_new, n_out_new;
    logic [smci_pkg::MAXST_W-1:0]    r_out_max, n_out_max;
    smci_pkg::t_status               r_out_status, n_out_status;

    logic                            vt_wr_en;
    logic [IDX_W-1:0]                vt_wr_addr;
    logic                            vt_rd_en;
    logic [IDX_W-1:0]                vt_rd_addr;
    logic [MASK_BITS-1:0]            vt_rd_data;

    logic                            cs_clr;
    logic                            cs_wr_en;
    logic                            cs_wr_set;
    logic [IDX_W-1:0]                cs_wr_addr;
    logic [IDX_W-1:0]                cs_wr_code;
    logic [IDX_W-1:0]                cs_rd_addr;
    logic                            cs_rd_hit;
    logic [IDX_W-1:0]                cs_rd_code;
    logic [MASK_BITS-1:0]            cs_rd_mask;

    logic                            in_fire;
    logic [IDX_W-1:0]                in_idx;
    logic [MASK_BITS-1:0]            in_mask;
    logic                            in_ch_ok;
    logic                            table_full;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && (r_state == S_IDLE);
    assign in_idx     = i_in.char_code[IDX_W-1:0];
    assign in_mask    = i_in.state_mask[MASK_BITS-1:0];
    assign in_ch_ok   = {1'b0, i_in.char_code} < (smci_pkg::CHAR_W + 1)'(ALPHABET_SIZE);
    assign table_full = ({1'b0, r_count} + (CNT_W + 1)'(1)) >= (CNT_W + 1)'(ALPHABET_SIZE);

    smci_value_table #(
        .DEPTH (ALPHABET_SIZE),
        .WIDTH (MASK_BITS)
    ) u_value_table (
        .i_clk     (i_clk),
        .i_wr_en   (vt_wr_en),
        .i_wr_addr (vt_wr_addr),
        .i_wr_data (r_mask),
        .i_rd_en   (vt_rd_en),
        .i_rd_addr (vt_rd_addr),
        .o_rd_data (vt_rd_data)
    );

    smci_char_store #(
        .DEPTH     (ALPHABET_SIZE),
        .MASK_BITS (MASK_BITS)
    ) u_char_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (cs_clr),
        .i_wr_en   (cs_wr_en),
        .i_wr_set  (cs_wr_set),
        .i_wr_addr (cs_wr_addr),
        .i_wr_code (cs_wr_code),
        .i_wr_mask (r_mask),
        .i_rd_addr (cs_rd_addr),
        .o_rd_hit  (cs_rd_hit),
        .o_rd_code (cs_rd_code),
        .o_rd_mask (cs_rd_mask)
    );

    always_comb begin
        n_state      = r_state;
        n_nt         = r_nt;
        n_count      = r_count;
        n_largest    = r_largest;
        n_idx        = r_idx;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid;
        n_ch_idx     = r_ch_idx;
        n_mask       = r_mask;
        n_pidx       = r_pidx;
        n_res_code   = r_res_code;
        n_res_new    = r_res_new;
        n_res_status = r_res_status;
        n_out_code   = r_out_code;
        n_out_new    = r_out_new;
        n_out_max    = r_out_max;
        n_out_status = r_out_status;

        vt_wr_en   = 1'b0;
        vt_wr_addr = r_count[IDX_W-1:0];
        vt_rd_en   = 1'b0;
        vt_rd_addr = r_idx[IDX_W-1:0];
        cs_clr     = 1'b0;
        cs_wr_en   = 1'b0;
        cs_wr_set  = 1'b0;
        cs_wr_addr = r_ch_idx;
        cs_wr_code = r_pidx;
        cs_rd_addr = in_idx;

        if (i_cfg_wr_en) begin
            n_nt = i_cfg_wr_data;
        end

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_ch_idx     = in_idx;
                    n_mask       = in_mask;
                    n_res_code   = '0;
                    n_res_new    = 1'b0;
                    n_res_status = smci_pkg::ST_OK;
                    n_idx        = '0;
                    n_pend       = 1'b0;
                    case (smci_pkg::t_cmd'(i_in.command))
                        smci_pkg::CMD_CLEAR: begin
                            n_count   = '0;
                            n_largest = '0;
                            cs_clr    = 1'b1;
                            n_state   = S_DONE;
                        end
                        smci_pkg::CMD_MAP: begin
                            if (!in_ch_ok) begin
                                n_state = S_DONE;
                            end else if (in_mask == '0) begin
                                cs_wr_en   = 1'b1;
                                cs_wr_addr = in_idx;
                                n_state    = S_DONE;
                            end else begin
                                n_state = S_SEARCH;
                            end
                        end
                        smci_pkg::CMD_XLATE: begin
                            if (!in_ch_ok) begin
                                n_res_status = smci_pkg::ST_ILLEGAL;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_XLATE;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (r_pend && vt_rd_data == r_mask) begin
                    cs_wr_en   = 1'b1;
                    cs_wr_set  = 1'b1;
                    n_res_code = smci_pkg::CODE_W'(r_pidx);
                    n_state    = S_DONE;
                end else if (!r_pend && r_idx >= r_count) begin
                    cs_wr_en = 1'b1;
                    n_state  = S_DONE;
                    if (table_full) begin
                        n_res_status = smci_pkg::ST_FULL;
                    end else begin
                        vt_wr_en   = 1'b1;
                        n_count    = r_count + CNT_W'(1);
                        n_largest  = (r_mask > r_largest) ? r_mask : r_largest;
                        cs_wr_set  = 1'b1;
                        cs_wr_code = r_count[IDX_W-1:0];
                        n_res_code = smci_pkg::CODE_W'(r_count);
                        n_res_new  = 1'b1;
                    end
                end else begin
                    vt_rd_en = (r_idx < r_count);
                    n_pend   = vt_rd_en;
                    n_pidx   = r_idx[IDX_W-1:0];
                    if (vt_rd_en) begin
                        n_idx = r_idx + CNT_W'(1);
                    end
                end
            end
            S_XLATE: begin
                if (!cs_rd_hit) begin
                    n_res_status = smci_pkg::ST_ILLEGAL;
                end else if (r_nt) begin
                    n_res_code = smci_pkg::CODE_W'(cs_rd_mask);
                end else begin
                    n_res_code = smci_pkg::CODE_W'(cs_rd_code);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_code   = r_res_code;
                    n_out_new    = r_res_new;
                    n_out_status = r_res_status;
                    n_out_max    = r_nt ? smci_pkg::MAXST_W'(r_largest) + smci_pkg::MAXST_W'(1)
                                        : smci_pkg::MAXST_W'(r_count);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_nt        <= 1'b0;
            r_count     <= '0;
            r_largest   <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_nt        <= n_nt;
            r_count     <= n_count;
            r_largest   <= n_largest;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch_idx     <= n_ch_idx;
        r_mask       <= n_mask;
        r_pidx       <= n_pidx;
        r_res_code   <= n_res_code;
        r_res_new    <= n_res_new;
        r_res_status <= n_res_status;
        r_out_code   <= n_out_code;
        r_out_new    <= n_out_new;
        r_out_max    <= n_out_max;
        r_out_status <= n_out_status;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.code       = r_out_code;
    assign o_out.is_new     = r_out_new;
    assign o_out.max_states = r_out_max;
    assign o_out.status     = r_out_status;

endmodule

>>> rtl/smci_checker.sv
// Port checker for the mask interning block and the bind that attaches it.
`timescale 1ns / 1ps

module smci_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [smci_pkg::CODE_W-1:0]     i_out_code,
    input  logic                            i_out_is_new,
    input  logic [smci_pkg::STATUS_W-1:0]   i_out_status
);

    // A stalled result word keeps its payload.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_code)
            && $stable(i_out_status) && $stable(i_out_is_new))
    else $error("result word changed while stalled");

    // Any failing status carries a zero code.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status != smci_pkg::ST_OK |-> i_out_code == '0)
    else $error("nonzero code with failing status");

    // A newly appended value is a success and its code fits the table.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_is_new |-> i_out_status == smci_pkg::ST_OK
            && i_out_code[smci_pkg::CODE_W-1:smci_pkg::CHAR_W] == '0)
    else $error("appended value with bad status or code");

    // A fresh result follows an accepted word or a busy period.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid || !i_in_ready))
    else $error("result word without a command word");

endmodule

bind state_mask_code_interning smci_checker u_smci_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_code   (o_out.code),
    .i_out_is_new (o_out.is_new),
    .i_out_status (o_out.status)
);
